/* hw/rtl/lav_pkg.sv */
// Shared types and constants for the look-at view matrix block.
package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 288;
    localparam int OUT_DATA_W    = 128;
    localparam int OUT_USER_W    = 6;
    localparam int EL_W          = 33;
    localparam int QUEUE_DEPTH   = 2;

    // three vector elements, signed, sign extended to EL_W bits
    typedef logic [2:0][EL_W-1:0] t_vec3;
    typedef logic [2:0][31:0]     t_eye3;

    // one classified word handed from the front end to the back end
    typedef struct packed {
        t_eye3 eye;
        t_vec3 ds;
        t_vec3 us;
        logic  bad;
    } t_job;

endpackage

/* hw/rtl/lav_bscale.sv */
// Block scaler: shifts a vector one bit a cycle until its largest magnitude sits in [2^29, 2^30).
module lav_bscale #(
    parameter int W = 33
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2:0][W-1:0]   i_vec,
    output logic                o_done,
    output logic                o_zero,
    output lav_pkg::t_vec3      o_vec
);

    localparam logic [1:0] BS_IDLE  = 2'd0;
    localparam logic [1:0] BS_MAX   = 2'd1;
    localparam logic [1:0] BS_SHIFT = 2'd2;

    logic [1:0]         r_st;
    logic [2:0][W-1:0]  r_mag;
    logic [2:0]         r_sgn;
    logic [W-1:0]       r_m;
    logic [W-1:0]       max01;
    logic               m_hi;
    logic               m_lo;
    logic               m_zero;
    logic [lav_pkg::EL_W-1:0] mag_ext [3];

    assign m_hi   = |r_m[W-1:30];
    assign m_lo   = ~|r_m[W-1:29];
    assign m_zero = (r_m == '0);
    assign max01  = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];

    assign o_done = (r_st == BS_SHIFT) && (m_zero || (!m_hi && !m_lo));
    assign o_zero = m_zero;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_ext[k] = {2'b00, r_mag[k][30:0]};
            o_vec[k]   = r_sgn[k] ? (-mag_ext[k]) : mag_ext[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BS_IDLE;
        end else begin
            unique case (r_st)
                BS_IDLE: begin
                    if (i_start) begin
                        for (int k = 0; k < 3; k++) begin
                            r_sgn[k] <= i_vec[k][W-1];
                            r_mag[k] <= i_vec[k][W-1] ? (W'(0) - i_vec[k]) : i_vec[k];
                        end
                        r_st <= BS_MAX;
                    end
                end
                BS_MAX: begin
                    r_m  <= (max01 > r_mag[2]) ? max01 : r_mag[2];
                    r_st <= BS_SHIFT;
                end
                BS_SHIFT: begin
                    if (m_zero || (!m_hi && !m_lo)) begin
                        r_st <= BS_IDLE;
                    end else if (m_hi) begin
                        // right shifts truncate each step, same as one long shift
                        r_m <= r_m >> 1;
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                    end else begin
                        r_m <= r_m << 1;
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                    end
                end
                default: r_st <= BS_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/lav_front.sv */
// Front end: takes input words, forms target minus eye and block-scales direction and up.
module lav_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [lav_pkg::IN_W-1:0]   i_data,
    output logic                       o_job_valid,
    input  logic                       i_job_ready,
    output lav_pkg::t_job              o_job
);

    localparam logic [1:0] FR_IDLE  = 2'd0;
    localparam logic [1:0] FR_SCALE = 2'd1;
    localparam logic [1:0] FR_PUSH  = 2'd2;

    logic [1:0]        r_st;
    lav_pkg::t_eye3    r_eye;
    lav_pkg::t_vec3    r_ds;
    lav_pkg::t_vec3    r_us;
    logic              r_dd;
    logic              r_ud;
    logic              r_zd;
    logic              r_zu;

    logic              accept;
    logic [2:0][32:0]  dir;
    logic [2:0][31:0]  upv;
    lav_pkg::t_eye3    eye_in;
    logic              d_done;
    logic              d_zero;
    logic              u_done;
    logic              u_zero;
    lav_pkg::t_vec3    d_vec;
    lav_pkg::t_vec3    u_vec;

    assign o_ready = (r_st == FR_IDLE);
    assign accept  = o_ready && i_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            eye_in[k] = i_data[32*k +: 32];
            upv[k]    = i_data[192 + 32*k +: 32];
            // exact 33-bit difference
            dir[k]    = {i_data[96 + 32*k + 31], i_data[96 + 32*k +: 32]}
                        - {eye_in[k][31], eye_in[k]};
        end
    end

    lav_bscale #(.W(33)) u_dir_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_vec   (dir),
        .o_done  (d_done),
        .o_zero  (d_zero),
        .o_vec   (d_vec)
    );

    lav_bscale #(.W(32)) u_up_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_vec   (upv),
        .o_done  (u_done),
        .o_zero  (u_zero),
        .o_vec   (u_vec)
    );

    assign o_job_valid = (r_st == FR_PUSH);
    assign o_job       = '{eye: r_eye, ds: r_ds, us: r_us, bad: r_zd | r_zu};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FR_IDLE;
            r_dd <= 1'b0;
            r_ud <= 1'b0;
        end else begin
            unique case (r_st)
                FR_IDLE: begin
                    if (accept) begin
                        r_eye <= eye_in;
                        r_dd  <= 1'b0;
                        r_ud  <= 1'b0;
                        r_st  <= FR_SCALE;
                    end
                end
                FR_SCALE: begin
                    if (d_done) begin
                        r_ds <= d_vec;
                        r_zd <= d_zero;
                        r_dd <= 1'b1;
                    end
                    if (u_done) begin
                        r_us <= u_vec;
                        r_zu <= u_zero;
                        r_ud <= 1'b1;
                    end
                    if ((r_dd || d_done) && (r_ud || u_done)) r_st <= FR_PUSH;
                end
                FR_PUSH: begin
                    if (i_job_ready) r_st <= FR_IDLE;
                end
                default: r_st <= FR_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/lav_queue.sv */
// Short queue of classified words between front and back end.
module lav_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lav_pkg::t_job   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output lav_pkg::t_job   o_data
);

    localparam int DEPTH = lav_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lav_pkg::t_job  r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           push;
    logic           pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (push && !pop)      r_cnt <= r_cnt + CW'(1);
            else if (pop && !push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

/* hw/rtl/lav_back.sv */
// Back end: shared multiplier, square root and divider sequencer, then twelve-row output stage.
module lav_back #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    output logic                             o_job_ready,
    input  lav_pkg::t_job                    i_job,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [lav_pkg::OUT_DATA_W-1:0]   o_tdata,
    output logic [lav_pkg::OUT_USER_W-1:0]   o_tuser,
    output logic                             o_tlast
);

    localparam int EW = lav_pkg::EL_W;
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + 31;
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [65:0] HALF = 66'd1 << (FRAC_BITS - 1);
    localparam logic [31:0] ONE  = 32'd1 << FRAC_BITS;

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_MUL   = 4'd1;
    localparam logic [3:0] B_ADD   = 4'd2;
    localparam logic [3:0] B_ABS   = 4'd3;
    localparam logic [3:0] B_WB    = 4'd4;
    localparam logic [3:0] B_SCLST = 4'd5;
    localparam logic [3:0] B_SCALE = 4'd6;
    localparam logic [3:0] B_SQRT  = 4'd7;
    localparam logic [3:0] B_DIVST = 4'd8;
    localparam logic [3:0] B_DIV   = 4'd9;
    localparam logic [3:0] B_EMIT  = 4'd10;

    localparam logic [3:0] SP_CXR = 4'd0;
    localparam logic [3:0] SP_SCL = 4'd1;
    localparam logic [3:0] SP_UZ  = 4'd2;
    localparam logic [3:0] SP_UX  = 4'd3;
    localparam logic [3:0] SP_Y   = 4'd4;
    localparam logic [3:0] SP_UU  = 4'd5;
    localparam logic [3:0] SP_ZB  = 4'd6;
    localparam logic [3:0] SP_TX  = 4'd7;
    localparam logic [3:0] SP_TY  = 4'd8;
    localparam logic [3:0] SP_TZ  = 4'd9;

    localparam logic [3:0] LAST_ROW = 4'd11;

    logic [3:0]          r_st;
    logic [3:0]          r_step;
    logic [1:0]          r_comp;
    logic [1:0]          r_term;
    logic                r_sub;
    lav_pkg::t_eye3      r_eye;
    lav_pkg::t_vec3      r_ds, r_us, r_sc, r_z, r_x, r_u, r_y, r_zb;
    logic [2:0][63:0]    r_cx;
    logic [2:0][31:0]    r_t;
    logic                r_bad;
    logic                r_sat;
    logic signed [65:0]  r_prod;
    logic signed [65:0]  r_acc;
    logic [65:0]         r_mag;
    logic                r_neg;
    logic [63:0]         r_rad, r_root, r_bit;
    logic [31:0]         r_n;
    logic [NW-1:0]       r_rem, r_dsh;
    logic [QW-1:0]       r_q;
    logic [CW-1:0]       r_dcnt;
    logic [3:0]          r_row;
    logic                r_ovalid;
    logic [lav_pkg::OUT_DATA_W-1:0] r_odata;
    logic [lav_pkg::OUT_USER_W-1:0] r_ouser;
    logic                r_olast;

    logic                pop;
    logic                is_cross;
    logic                last_term;
    lav_pkg::t_vec3      vec_a, vec_b, eye_ext;
    logic [1:0]          j1, j2, ia, ib;
    logic signed [EW-1:0] op_a, op_b;
    logic [65:0]         q_rnd, q_neg;
    logic [EW-1:0]       el_rnd;
    logic                t_sat;
    logic [31:0]         t_val;
    logic [63:0]         trial;
    logic                ge_d;
    logic [QW-1:0]       q_next;
    logic [EW-1:0]       q_ext, el_div, a_abs;
    logic [NW-1:0]       num;
    logic                sc_done, sc_zero;
    lav_pkg::t_vec3      sc_vec;
    logic                emit_load;
    logic [31:0]         c0, c1, c2, c3;

    function automatic logic [1:0] nxt(input logic [1:0] j);
        return (j == 2'd2) ? 2'd0 : j + 2'd1;
    endfunction

    assign pop         = (r_st == B_IDLE) && i_job_valid;
    assign o_job_ready = (r_st == B_IDLE);

    always_comb begin
        for (int k = 0; k < 3; k++) eye_ext[k] = {r_eye[k][31], r_eye[k]};
    end

    assign is_cross  = (r_step == SP_CXR) || (r_step == SP_Y) || (r_step == SP_ZB);
    assign last_term = is_cross ? (r_term == 2'd1) : (r_term == 2'd2);

    always_comb begin
        unique case (r_step)
            SP_CXR:  begin vec_a = r_us; vec_b = r_ds;    end
            SP_UZ:   begin vec_a = r_ds; vec_b = r_ds;    end
            SP_UX:   begin vec_a = r_sc; vec_b = r_sc;    end
            SP_Y:    begin vec_a = r_z;  vec_b = r_x;     end
            SP_UU:   begin vec_a = r_us; vec_b = r_us;    end
            SP_ZB:   begin vec_a = r_x;  vec_b = r_u;     end
            SP_TX:   begin vec_a = r_x;  vec_b = eye_ext; end
            SP_TY:   begin vec_a = r_y;  vec_b = eye_ext; end
            SP_TZ:   begin vec_a = r_z;  vec_b = eye_ext; end
            default: begin vec_a = r_ds; vec_b = r_ds;    end
        endcase
    end

    // cross: a[j+1]*b[j+2] - a[j+2]*b[j+1]; squares and dots walk the three terms
    assign j1 = nxt(r_comp);
    assign j2 = nxt(j1);
    assign ia = is_cross ? ((r_term == 2'd0) ? j1 : j2) : r_term;
    assign ib = is_cross ? ((r_term == 2'd0) ? j2 : j1) : r_term;
    assign op_a = $signed(vec_a[ia]);
    assign op_b = $signed(vec_b[ib]);

    // rounding half away from zero, then the negated, clamped translation
    assign q_rnd  = r_mag >> FRAC_BITS;
    assign q_neg  = 66'd0 - q_rnd;
    assign el_rnd = r_neg ? q_neg[EW-1:0] : q_rnd[EW-1:0];

    always_comb begin
        if (r_neg) begin
            t_sat = |q_rnd[65:31];
            t_val = t_sat ? 32'h7FFF_FFFF : q_rnd[31:0];
        end else begin
            t_sat = (|q_rnd[65:32]) || (q_rnd[31] && (|q_rnd[30:0]));
            t_val = t_sat ? 32'h8000_0000 : q_neg[31:0];
        end
    end

    assign trial  = r_root + r_bit;
    assign ge_d   = (r_rem >= r_dsh);
    assign q_next = {r_q[QW-2:0], ge_d};
    assign q_ext  = EW'(q_next);
    assign el_div = vec_a[r_comp][EW-1] ? (EW'(0) - q_ext) : q_ext;
    assign a_abs  = vec_a[r_comp][EW-1] ? (EW'(0) - vec_a[r_comp]) : vec_a[r_comp];
    assign num    = (NW'(a_abs[30:0]) << FRAC_BITS) + NW'(r_n >> 1);

    lav_bscale #(.W(64)) u_cx_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_st == B_SCLST),
        .i_vec   (r_cx),
        .o_done  (sc_done),
        .o_zero  (sc_zero),
        .o_vec   (sc_vec)
    );

    // row contents
    always_comb begin
        c0 = '0; c1 = '0; c2 = '0; c3 = '0;
        if (!r_bad) begin
            unique case (r_row[1:0])
                2'd3: begin
                    c3 = ONE;
                    if (r_row[3:2] == 2'd0) begin
                        c0 = r_t[0]; c1 = r_t[1]; c2 = r_t[2];
                    end
                end
                default: begin
                    if (r_row[3:2] == 2'd0) begin
                        c0 = r_x[r_row[1:0]][31:0];
                        c1 = r_y[r_row[1:0]][31:0];
                        c2 = r_z[r_row[1:0]][31:0];
                    end else begin
                        unique case (r_row[1:0])
                            2'd0: begin
                                c0 = r_x[0][31:0]; c1 = r_x[1][31:0]; c2 = r_x[2][31:0];
                            end
                            2'd1: begin
                                if (r_row[3:2] == 2'd1) begin
                                    c0 = r_y[0][31:0]; c1 = r_y[1][31:0]; c2 = r_y[2][31:0];
                                end else begin
                                    c0 = r_u[0][31:0]; c1 = r_u[1][31:0]; c2 = r_u[2][31:0];
                                end
                            end
                            default: begin
                                if (r_row[3:2] == 2'd1) begin
                                    c0 = r_z[0][31:0]; c1 = r_z[1][31:0]; c2 = r_z[2][31:0];
                                end else begin
                                    c0 = r_zb[0][31:0]; c1 = r_zb[1][31:0];
                                    c2 = r_zb[2][31:0];
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign emit_load = (r_st == B_EMIT) && (!r_ovalid || i_tready);

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = r_ouser;
    assign o_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= B_IDLE;
            r_ovalid <= 1'b0;
            r_row    <= '0;
        end else begin
            if (emit_load)     r_ovalid <= 1'b1;
            else if (i_tready) r_ovalid <= 1'b0;

            unique case (r_st)
                B_IDLE: begin
                    if (pop) begin
                        r_eye  <= i_job.eye;
                        r_ds   <= i_job.ds;
                        r_us   <= i_job.us;
                        r_bad  <= i_job.bad;
                        r_sat  <= 1'b0;
                        r_step <= SP_CXR;
                        r_comp <= '0;
                        r_term <= '0;
                        r_acc  <= '0;
                        r_row  <= '0;
                        r_st   <= i_job.bad ? B_EMIT : B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod <= op_a * op_b;
                    r_sub  <= is_cross && (r_term == 2'd1);
                    r_st   <= B_ADD;
                end
                B_ADD: begin
                    r_acc <= r_sub ? (r_acc - r_prod) : (r_acc + r_prod);
                    if (last_term) begin
                        r_st <= B_ABS;
                    end else begin
                        r_term <= r_term + 2'd1;
                        r_st   <= B_MUL;
                    end
                end
                B_ABS: begin
                    r_neg <= r_acc[65];
                    r_mag <= (r_acc[65] ? (66'd0 - r_acc) : r_acc) + HALF;
                    r_st  <= B_WB;
                end
                B_WB: begin
                    priority if (r_step == SP_CXR) begin
                        r_cx[r_comp] <= r_acc[63:0];
                        if (r_comp == 2'd2) begin
                            r_st <= B_SCLST;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                            r_term <= '0;
                            r_acc  <= '0;
                            r_st   <= B_MUL;
                        end
                    end else if (r_step == SP_Y || r_step == SP_ZB) begin
                        if (r_step == SP_Y) r_y[r_comp]  <= el_rnd;
                        else                r_zb[r_comp] <= el_rnd;
                        r_term <= '0;
                        r_acc  <= '0;
                        r_st   <= B_MUL;
                        if (r_comp == 2'd2) begin
                            r_comp <= '0;
                            r_step <= r_step + 4'd1;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end else if (r_step == SP_UZ || r_step == SP_UX || r_step == SP_UU) begin
                        r_rad  <= r_acc[63:0];
                        r_root <= '0;
                        r_bit  <= 64'd1 << 62;
                        r_st   <= B_SQRT;
                    end else begin
                        r_t[2'(r_step - SP_TX)] <= t_val;
                        r_sat  <= r_sat | t_sat;
                        r_term <= '0;
                        r_acc  <= '0;
                        if (r_step == SP_TZ) begin
                            r_row <= '0;
                            r_st  <= B_EMIT;
                        end else begin
                            r_step <= r_step + 4'd1;
                            r_st   <= B_MUL;
                        end
                    end
                end
                B_SCLST: r_st <= B_SCALE;
                B_SCALE: begin
                    if (sc_done) begin
                        if (sc_zero) begin
                            // up parallel to the view direction
                            r_bad <= 1'b1;
                            r_row <= '0;
                            r_st  <= B_EMIT;
                        end else begin
                            r_sc   <= sc_vec;
                            r_step <= SP_UZ;
                            r_comp <= '0;
                            r_term <= '0;
                            r_acc  <= '0;
                            r_st   <= B_MUL;
                        end
                    end
                end
                B_SQRT: begin
                    if (r_bit == '0) begin
                        r_n    <= r_root[31:0];
                        r_comp <= '0;
                        r_st   <= B_DIVST;
                    end else begin
                        if (r_rad >= trial) begin
                            r_rad  <= r_rad - trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                B_DIVST: begin
                    r_rem  <= num;
                    r_dsh  <= NW'(r_n) << FRAC_BITS;
                    r_q    <= '0;
                    r_dcnt <= CW'(FRAC_BITS);
                    r_st   <= B_DIV;
                end
                B_DIV: begin
                    if (ge_d) r_rem <= r_rem - r_dsh;
                    r_dsh <= r_dsh >> 1;
                    r_q   <= q_next;
                    if (r_dcnt == '0) begin
                        unique case (r_step)
                            SP_UZ:   r_z[r_comp] <= el_div;
                            SP_UX:   r_x[r_comp] <= el_div;
                            default: r_u[r_comp] <= el_div;
                        endcase
                        if (r_comp == 2'd2) begin
                            r_comp <= '0;
                            r_term <= '0;
                            r_acc  <= '0;
                            r_step <= r_step + 4'd1;
                            r_st   <= B_MUL;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                            r_st   <= B_DIVST;
                        end
                    end else begin
                        r_dcnt <= r_dcnt - CW'(1);
                    end
                end
                B_EMIT: begin
                    if (emit_load) begin
                        r_odata <= {c3, c2, c1, c0};
                        r_ouser <= {r_sat, r_bad, r_row[1:0], r_row[3:2]};
                        r_olast <= (r_row == LAST_ROW);
                        if (r_row == LAST_ROW) begin
                            r_row <= '0;
                            r_st  <= B_IDLE;
                        end else begin
                            r_row <= r_row + 4'd1;
                        end
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/look_at_view_matrix.sv */
// Look-at view matrix top level: front end, word queue and back end with output stage.
//
// Each input word (eye, target, up; signed fixed point with FRAC_BITS fraction bits) yields
// twelve output words: the four rows of the view matrix, then the full billboard and the
// Y-axis billboard. The back end works through the shared 33x33 multiplier, the 32-step
// square root, run three times, and the FRAC_BITS+1 step divider, run for each element of
// the three unit vectors. A zero direction or up vector is flagged in the front end, a
// parallel one once the back end finds a zero cross product. The front end scales the
// next word and a two-entry queue holds it while the back end works, and the output
// register lets the sequencer start the next word while the last row waits.
module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // eye_x, eye_y, eye_z, look_x, look_y, look_z, up_x, up_y, up_z (32 bits each)
    input  logic [lav_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // col0, col1, col2, col3 (32 bits each)
    output logic [lav_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // matrix_sel[1:0], row_index[3:2], bad_basis[4], saturated[5]
    output logic [lav_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast
);

    logic           f_valid, f_ready;
    logic           q_valid, q_ready;
    lav_pkg::t_job  f_job, q_job;

    lav_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    lav_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_job)
    );

    lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );

    // a failed basis gives zero rows and never a clamp
    a_bad_rows_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[4]) |-> (m_axis_tdata == '0 && !m_axis_tuser[5]))
        else $error("bad basis word with nonzero row");

    // tlast marks exactly the last row of the Y billboard
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == 2'd2 &&
                                            m_axis_tuser[3:2] == 2'd3)))
        else $error("tlast out of place");

    // rows follow each other with no gap or repeat
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (!m_axis_tvalid || ({m_axis_tuser[1:0], m_axis_tuser[3:2]} ==
                            $past({m_axis_tuser[1:0], m_axis_tuser[3:2]}) + 4'd1)))
        else $error("row sequence broken");

endmodule

/* verif/look_at_view_matrix_test.sv */
// Testbench for the look-at view matrix block: stream stimulus, row predictor, scoreboard.
`timescale 1ns / 1ps

module look_at_view_matrix_test;

    localparam int FB = lav_pkg::FRAC_BITS_DEF;
    localparam longint LIMIT = 2000000;

    typedef struct {
        logic [1:0]  msel;
        logic [1:0]  row;
        logic [31:0] col [4];
        logic        last;
        logic        bad;
        logic        sat;
    } t_row;

    function automatic longint unsigned mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic bit scale_block(longint v [3], output longint o [3]);
        longint unsigned m, a;
        int upsh, dnsh;
        m = 0; upsh = 0; dnsh = 0;
        for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
        if (m == 0) begin
            o = '{0, 0, 0};
            return 0;
        end
        while (m >= 64'd1 << 30) begin m >>= 1; dnsh++; end
        while (m < 64'd1 << 29) begin m <<= 1; upsh++; end
        for (int i = 0; i < 3; i++) begin
            a = mag(v[i]);
            a = dnsh != 0 ? a >> dnsh : a << upsh;
            o[i] = v[i] < 0 ? -longint'(a) : longint'(a);
        end
        return 1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_frac(longint a);
        longint unsigned q;
        q = (mag(a) + (64'd1 << (FB - 1))) >> FB;
        return a < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic void normalise(longint v [3], output longint o [3]);
        longint s [3];
        longint unsigned sum, n, q;
        void'(scale_block(v, s));
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag(s[i]) * mag(s[i]);
        n = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag(s[i]) << FB) + n / 2) / n;
            o[i] = s[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross3(longint a [3], longint b [3], output longint o [3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic longint neg_dot_clamp(longint a [3], longint e [3], ref bit sat);
        longint t;
        t = -round_frac(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
        if (t > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
        if (t < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
        return t;
    endfunction

    function automatic void look_rows(logic [31:0] f [9], output t_row rs [12]);
        longint eye [3], upv [3], dir [3], ds [3], us [3], cx [3];
        longint bx [3], by [3], bz [3], bu [3], zb [3], tr [3], tmp [3];
        longint m [12][4];
        bit bad, sat;
        bad = 0; sat = 0;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'(signed'(f[i]));
            upv[i] = longint'(signed'(f[6 + i]));
            dir[i] = longint'(signed'(f[3 + i])) - eye[i];
        end
        if (!scale_block(dir, ds) || !scale_block(upv, us)) bad = 1;
        else begin
            cross3(us, ds, cx);
            if (cx[0] == 0 && cx[1] == 0 && cx[2] == 0) bad = 1;
        end
        for (int k = 0; k < 12; k++) for (int i = 0; i < 4; i++) m[k][i] = 0;
        if (!bad) begin
            normalise(ds, bz);
            normalise(cx, bx);
            cross3(bz, bx, tmp);
            for (int i = 0; i < 3; i++) by[i] = round_frac(tmp[i]);
            normalise(us, bu);
            cross3(bx, bu, tmp);
            for (int i = 0; i < 3; i++) zb[i] = round_frac(tmp[i]);
            tr[0] = neg_dot_clamp(bx, eye, sat);
            tr[1] = neg_dot_clamp(by, eye, sat);
            tr[2] = neg_dot_clamp(bz, eye, sat);
            for (int i = 0; i < 3; i++) begin
                m[i][0] = bx[i]; m[i][1] = by[i]; m[i][2] = bz[i];
                m[3][i] = tr[i];
                m[4][i] = bx[i]; m[5][i] = by[i]; m[6][i] = bz[i];
                m[8][i] = bx[i]; m[9][i] = bu[i]; m[10][i] = zb[i];
            end
            m[3][3] = 64'd1 << FB; m[7][3] = 64'd1 << FB; m[11][3] = 64'd1 << FB;
        end
        for (int k = 0; k < 12; k++) begin
            rs[k].msel = 2'(k / 4);
            rs[k].row  = 2'(k % 4);
            for (int i = 0; i < 4; i++) rs[k].col[i] = m[k][i][31:0];
            rs[k].last = (k == 11);
            rs[k].bad  = bad;
            rs[k].sat  = sat;
        end
    endfunction

    // Scoreboard: queue of predicted rows, compares rows leaving the block
    class row_scoreboard;
        t_row   pending[$];
        int     mismatches;

        function void note_input(logic [31:0] f [9]);
            t_row rs[12];
            look_rows(f, rs);
            foreach (rs[k]) pending.push_back(rs[k]);
        endfunction

        function void check_row(t_row got);
            t_row exp;
            bit ok;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row sel=%0d row=%0d", got.msel, got.row);
                return;
            end
            exp = pending.pop_front();
            ok = exp.msel == got.msel && exp.row == got.row && exp.last == got.last &&
                 exp.bad == got.bad && exp.sat == got.sat;
            for (int i = 0; i < 4; i++) ok &= exp.col[i] == got.col[i];
            if (!ok) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("row mismatch exp sel%0d r%0d %h %h %h %h l%0b b%0b s%0b",
                        exp.msel, exp.row, exp.col[0], exp.col[1], exp.col[2], exp.col[3],
                        exp.last, exp.bad, exp.sat);
                    $display("             got sel%0d r%0d %h %h %h %h l%0b b%0b s%0b",
                        got.msel, got.row, got.col[0], got.col[1], got.col[2], got.col[3],
                        got.last, got.bad, got.sat);
                end
            end
        endfunction
    endclass

    logic                          i_clk = 0;
    logic                          i_rst_n = 0;
    logic                          s_axis_tvalid = 0;
    logic                          s_axis_tready;
    // eye_x, eye_y, eye_z, look_x, look_y, look_z, up_x, up_y, up_z
    logic [lav_pkg::IN_W-1:0]      s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 0;
    // col0, col1, col2, col3
    logic [lav_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // matrix_sel[1:0], row_index[3:2], bad_basis[4], saturated[5]
    logic [lav_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic                          m_axis_tlast;

    look_at_view_matrix DUT (.*);

    always #5 i_clk = ~i_clk;

    row_scoreboard rows_sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    longint cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: sample at the rising edge, set ready at the falling edge
    always @(posedge i_clk) begin
        t_row got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.msel = m_axis_tuser[1:0];
            got.row  = m_axis_tuser[3:2];
            got.bad  = m_axis_tuser[4];
            got.sat  = m_axis_tuser[5];
            got.last = m_axis_tlast;
            for (int i = 0; i < 4; i++) got.col[i] = m_axis_tdata[32*i +: 32];
            rows_sb.check_row(got);
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);

    // called at a falling edge; tvalid stays high until the next word or an idle cycle
    task automatic send_view(logic [31:0] f [9]);
        logic [lav_pkg::IN_W-1:0] d;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        for (int i = 0; i < 9; i++) d[32*i +: 32] = f[i];
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
        rows_sb.note_input(f);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h7fff) - 32'h4000;
            2: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff);
            default: return signed'($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] f [9];
        int r;
        for (int i = 0; i < 9; i++) f[i] = rand_val();
        r = $urandom_range(19);
        if (r == 0) for (int i = 0; i < 3; i++) f[3 + i] = f[i];
        else if (r == 1) for (int i = 0; i < 3; i++) f[6 + i] = 0;
        else if (r == 2) for (int i = 0; i < 3; i++) f[6 + i] = f[3 + i] - f[i];
        send_view(f);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (rows_sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MX  = 32'h7fff_ffff;
    localparam logic [31:0] MN  = 32'h8000_0000;

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        // directed: ordinary view, zero direction, zero up, parallel up, extremes
        send_view('{0, 0, 0, 0, 0, ONE, 0, ONE, 0});
        send_view('{ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0});
        send_view('{0, 0, 0, ONE, 0, 0, 0, 0, 0});
        send_view('{0, 0, 0, 0, ONE, 0, 0, 5*ONE, 0});
        send_view('{MX, MX, MX, MN, MN, MN, 0, ONE, 0});
        send_view('{MN, MN, MN, MX, MX, MX, ONE, 0, 0});
        send_view('{MX, MN, MX, MN, MX, MN, MX, MN, MX});
        send_view('{MN, 0, MX, 0, 0, 0, MN, MN, MN});
        send_view('{0, 0, 0, 1, 0, 0, 0, 1, 1});
        send_view('{32'hffff_ffff, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 0});
        send_view('{MX, MX, MX, 0, 0, 0, MX, 1, MN});
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = phase == 1 || phase == 3 ? (phase == 1 ? 79 : 15) : 0;
            recv_stall_pct = phase == 2 ? 79 : (phase == 3 ? 15 : 0);
            for (int n = 0; n < 35; n++) send_random();
            if (phase == 1) drain();
        end
        drain();
        if (rows_sb.mismatches == 0 && rows_sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
